// File: rtl/core/lnfmt_pkg.sv
// Shared types and constants of the line formatter core.
package lnfmt_pkg;

   // Register indexes of the configuration channel
   localparam logic [2:0] CSR_NUMBER_ALL      = 3'd0;
   localparam logic [2:0] CSR_NUMBER_NONBLANK = 3'd1;
   localparam logic [2:0] CSR_SQUEEZE_BLANK   = 3'd2;
   localparam logic [2:0] CSR_SHOW_ENDS       = 3'd3;
   localparam logic [2:0] CSR_SHOW_TABS       = 3'd4;
   localparam logic [2:0] CSR_SHOW_NONPRINT   = 3'd5;

   // Character codes
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_I      = 8'h49;
   localparam logic [7:0] CHAR_CARET  = 8'h5E;
   localparam logic [7:0] CHAR_DEL    = 8'h7F;

   // Command queue between front and back; depth is a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic number_all_lines;
      logic number_nonblank_lines;
      logic squeeze_blank;
      logic show_ends;
      logic show_tabs;
      logic show_nonprinting;
   } cfg_type;

   // What the back end emits for one input byte, in this order:
   // number field + tab, '$', '^', body byte
   typedef struct packed {
      logic       num;
      logic       dollar;
      logic       caret;
      logic       body_valid;
      logic [7:0] body;
   } cmd_type;

endpackage

// File: rtl/core/lnfmt_front.sv
// Front end: accepts input bytes, tracks line state and builds emit commands.
module lnfmt_front
   import lnfmt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       queue_full,
   output logic       push,
   output cmd_type    push_cmd
);

   logic [1:0] run_ff, run_in;
   logic       pend_all_ff, pend_all_in;
   logic       pend_nb_ff, pend_nb_in;

   logic       accept;
   logic       nl;
   logic       keep;
   logic       all_on;
   logic       np;
   logic [7:0] c_mod;
   logic       tab;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      nl = (req_tdata == CHAR_NL);

      run_in = run_ff;
      if (cfg.squeeze_blank) begin
         if (nl) begin
            run_in = (run_ff == 2'd3) ? 2'd3 : run_ff + 2'd1;
         end else begin
            run_in = 2'd0;
         end
      end
      keep = !(cfg.squeeze_blank && (run_in == 2'd3));

      all_on      = cfg.number_all_lines && !cfg.number_nonblank_lines && keep;
      pend_all_in = all_on ? nl : pend_all_ff;
      pend_nb_in  = cfg.number_nonblank_lines ? nl : pend_nb_ff;

      np = cfg.show_nonprinting &&
           ((req_tdata <= 8'd8) ||
            ((req_tdata >= 8'd11) && (req_tdata <= 8'd31)) ||
            (req_tdata == CHAR_DEL));
      // (c + 64) mod 128 flips bit 6 of a 7-bit code
      c_mod = np ? {1'b0, req_tdata[6:0] + 7'h40} : req_tdata;
      tab   = cfg.show_tabs && (c_mod == CHAR_TAB);

      push_cmd.num        = (all_on && pend_all_ff) ||
                            (cfg.number_nonblank_lines && !nl && pend_nb_ff);
      push_cmd.dollar     = cfg.show_ends && nl && keep;
      push_cmd.caret      = keep && (np || tab);
      push_cmd.body_valid = keep;
      push_cmd.body       = tab ? CHAR_I : c_mod;
   end

   // squeezed newlines make no output and never reach the queue
   assign push = accept && (push_cmd.num || push_cmd.dollar ||
                            push_cmd.caret || push_cmd.body_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 2'd1;
         pend_all_ff <= 1'b1;
         pend_nb_ff  <= 1'b1;
      end else if (accept) begin
         run_ff      <= run_in;
         pend_all_ff <= pend_all_in;
         pend_nb_ff  <= pend_nb_in;
      end
   end

endmodule

// File: rtl/core/lnfmt_queue.sv
// Short command queue between front and back ends.
module lnfmt_queue
   import lnfmt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head
);

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/core/lnfmt_back.sv
// Back end: serializes one command into output beats, owns the line counter.
module lnfmt_back
   import lnfmt_pkg::*;
#(
   parameter int NUMBER_DIGITS = 6,
   parameter int DIG_W         = 3
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cmd_type    head,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast
);

   localparam int BCD_W = 4 * NUMBER_DIGITS;

   localparam logic [2:0] PH_DIGIT  = 3'd0;
   localparam logic [2:0] PH_TAB    = 3'd1;
   localparam logic [2:0] PH_DOLLAR = 3'd2;
   localparam logic [2:0] PH_CARET  = 3'd3;
   localparam logic [2:0] PH_BODY   = 3'd4;

   logic             busy_ff, busy_in;
   logic [2:0]       phase_ff, phase_in;
   logic [DIG_W-1:0] dig_ff, dig_in;
   logic             seen_ff, seen_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             out_free;
   logic             step;
   logic [4:0]       act;
   logic [2:0]       first_idx;
   logic [2:0]       cur_phase;
   logic [2:0]       next_idx;
   logic             next_found;
   logic [DIG_W-1:0] cur_dig;
   logic [3:0]       digit;
   logic             seen_now;
   logic             more_digits;
   logic             is_last;
   logic [BCD_W-1:0] bcd_inc;
   logic             carry;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign step     = head_valid && out_free;
   assign act      = {head.body_valid, head.caret, head.dollar, head.num, head.num};

   always_comb begin
      first_idx = PH_BODY;
      for (int i = 4; i >= 0; i--) begin
         if (act[i]) begin
            first_idx = 3'(i);
         end
      end
      cur_phase = busy_ff ? phase_ff : first_idx;

      next_idx   = PH_BODY;
      next_found = 1'b0;
      for (int i = 4; i >= 0; i--) begin
         if (act[i] && (3'(i) > cur_phase)) begin
            next_idx   = 3'(i);
            next_found = 1'b1;
         end
      end
   end

   always_comb begin
      cur_dig     = busy_ff ? dig_ff : DIG_W'(NUMBER_DIGITS - 1);
      digit       = bcd_ff[cur_dig*4 +: 4];
      seen_now    = (busy_ff && seen_ff) || (digit != 4'd0) || (cur_dig == '0);
      more_digits = (cur_phase == PH_DIGIT) && (cur_dig != '0);
      is_last     = !more_digits && !next_found;

      unique case (cur_phase)
         PH_DIGIT:  rsp_data_in = seen_now ? (CHAR_ZERO | {4'd0, digit}) : CHAR_SPACE;
         PH_TAB:    rsp_data_in = CHAR_TAB;
         PH_DOLLAR: rsp_data_in = CHAR_DOLLAR;
         PH_CARET:  rsp_data_in = CHAR_CARET;
         PH_BODY:   rsp_data_in = head.body;
         default:   rsp_data_in = head.body;
      endcase
      rsp_last_in  = is_last;
      rsp_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

      busy_in  = step ? !is_last : busy_ff;
      phase_in = more_digits ? PH_DIGIT : next_idx;
      dig_in   = cur_dig - DIG_W'(1);
      seen_in  = seen_now;
   end

   // saturating BCD increment, digit by digit
   always_comb begin
      bcd_inc = bcd_ff;
      carry   = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         if (carry) begin
            if (bcd_ff[i*4 +: 4] == 4'd9) begin
               bcd_inc[i*4 +: 4] = 4'd0;
            end else begin
               bcd_inc[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd1;
               carry = 1'b0;
            end
         end
      end
      bcd_in = carry ? bcd_ff : bcd_inc;
   end

   assign pop        = step && is_last;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
         phase_ff    <= phase_in;
         dig_ff      <= dig_in;
         seen_ff     <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bcd_ff       <= BCD_W'(1);
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step && (cur_phase == PH_TAB)) begin
            bcd_ff <= bcd_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_busy_has_cmd: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> head_valid)
      else $error("back end mid-command with empty queue");

   a_bcd_only_on_tab: assert property (@(posedge clock) disable iff (reset)
      !(step && (cur_phase == PH_TAB)) |=> $stable(bcd_ff))
      else $error("line number changed outside a number field");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (phase_ff == PH_DIGIT)) |->
         ({1'b0, dig_ff} < (DIG_W+1)'(NUMBER_DIGITS)))
      else $error("digit index out of range");

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_tvalid && rsp_tlast))
      else $error("command retired without a last beat");
`endif

endmodule

// File: rtl/core/text_stream_line_formatter_core.sv
// Top level of the text stream line formatter core.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------
//  req     | in  | req_tvalid/req_tready | tdata[7:0] in_byte
//  rsp     | out | rsp_tvalid/rsp_tready | tdata[7:0] out_byte, tlast last_of_run
//  csr     | in  | csr_valid/csr_ready   | csr_index[2:0], csr_data (bit 0 kept)
//
//  Beats: the back end emits one output beat per cycle while it has a command
//    and rsp_tready allows, so a plain byte makes one beat and a numbered line
//    start up to NUMBER_DIGITS+3 beats; the back-end serializer sets the sustained rate.
//  Input bytes are taken one per cycle while the two-entry command queue has
//    room; a squeezed newline is taken and makes no beat.
//  Reset: options cleared, line number 1, numbers due, blank-run count 1.
//  Stalls: rsp_tready low holds the output register and backs up the queue,
//    and req_tready drops only when the queue is full.
module text_stream_line_formatter_core
   import lnfmt_pkg::*;
#(
   parameter int NUMBER_DIGITS = 6
)
(
   input  logic       clock,
   input  logic       reset,
   // input byte stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   // formatted output stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // last_of_run
   // option register writes
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic       csr_data
);

   localparam int DIG_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

   cfg_type cfg_ff, cfg_in;
   logic    queue_full;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head;

   // option writes are always taken; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NUMBER_ALL:      cfg_in.number_all_lines      = csr_data;
            CSR_NUMBER_NONBLANK: cfg_in.number_nonblank_lines = csr_data;
            CSR_SQUEEZE_BLANK:   cfg_in.squeeze_blank         = csr_data;
            CSR_SHOW_ENDS:       cfg_in.show_ends             = csr_data;
            CSR_SHOW_TABS:       cfg_in.show_tabs             = csr_data;
            CSR_SHOW_NONPRINT:   cfg_in.show_nonprinting      = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: classify each byte and update line state
   lnfmt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   lnfmt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head)
   );

   // back: expand commands into beats, keeps the BCD line counter
   lnfmt_back #(
      .NUMBER_DIGITS (NUMBER_DIGITS),
      .DIG_W         (DIG_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the text stream line formatter core.
`timescale 1ns / 1ps

module tb_top;
   import lnfmt_pkg::*;

   localparam int NDIG         = 6;
   localparam int DRAIN_CYCLES = 32;   // two queued bytes plus the output stage
   localparam int HOLD_CYCLES  = 300;  // long output stall, fills the queue
   localparam int PHASE_BYTES  = 30;
   localparam int SWEEP_LINES  = 60;   // numbered empty lines, several tens carries
   localparam logic [4*NDIG-1:0] BCD_MAX = {NDIG{4'h9}};

   // Option sets used by the directed table
   localparam cfg_type CFG_PLAIN = '0;
   localparam cfg_type CFG_SHOW_ALL = '{number_all_lines: 1'b1, number_nonblank_lines: 1'b0,
                                        squeeze_blank: 1'b1, show_ends: 1'b1,
                                        show_tabs: 1'b1, show_nonprinting: 1'b1};
   localparam cfg_type CFG_NONBLANK = '{number_all_lines: 1'b1, number_nonblank_lines: 1'b1,
                                        squeeze_blank: 1'b0, show_ends: 1'b1,
                                        show_tabs: 1'b0, show_nonprinting: 1'b0};

   typedef struct packed {
      logic [7:0] data;
      logic       end_of_run;
   } out_beat_type;

   // One directed input byte; typed rows carry their single output byte by hand
   typedef struct {
      cfg_type    opts;
      logic [7:0] in_byte;
      bit         typed;
      logic [7:0] echo;
   } dir_row_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_valid  = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index  = CSR_NUMBER_ALL;
   logic       csr_data   = 1'b0;

   // Predictor state, at its reset values
   cfg_type           opts        = '0;
   logic [1:0]        nl_run      = 2'd1;
   logic [4*NDIG-1:0] line_bcd    = (4*NDIG)'(1);
   logic              due_all      = 1'b1;
   logic              due_nonblank = 1'b1;

   logic [7:0]   run_bytes [$];     // output bytes of the byte being predicted
   out_beat_type pending_out [$];   // expected output beats, oldest first

   int  mism      = 0;
   bit  idle_on   = 1'b1;   // random idling on both sides
   bit  hold_req  = 1'b0;   // raised by the stimulus, served once by the output side
   bit  hold_done = 1'b0;
   int  hold_left = 0;

   dir_row_type dir_rows [0:23] = '{
      // reset options: every byte passes through as is
      '{CFG_PLAIN, 8'h00,    1'b1, 8'h00},
      '{CFG_PLAIN, 8'hFF,    1'b1, 8'hFF},
      '{CFG_PLAIN, CHAR_DEL, 1'b1, CHAR_DEL},
      '{CFG_PLAIN, 8'h80,    1'b1, 8'h80},
      '{CFG_PLAIN, CHAR_TAB, 1'b1, CHAR_TAB},
      '{CFG_PLAIN, CHAR_NL,  1'b1, CHAR_NL},
      '{CFG_PLAIN, 8'h41,    1'b1, 8'h41},
      // everything on: blank-run count still at its reset value of one,
      // so the second leading newline is already squeezed
      '{CFG_SHOW_ALL, CHAR_NL,  1'b0, 8'h00},
      '{CFG_SHOW_ALL, CHAR_NL,  1'b0, 8'h00},
      '{CFG_SHOW_ALL, CHAR_NL,  1'b0, 8'h00},
      '{CFG_SHOW_ALL, CHAR_TAB, 1'b0, 8'h00},
      '{CFG_SHOW_ALL, 8'h00,    1'b0, 8'h00},
      '{CFG_SHOW_ALL, 8'h1F,    1'b0, 8'h00},
      '{CFG_SHOW_ALL, CHAR_DEL, 1'b0, 8'h00},
      '{CFG_SHOW_ALL, 8'h0B,    1'b0, 8'h00},
      '{CFG_SHOW_ALL, 8'h08,    1'b0, 8'h00},
      '{CFG_SHOW_ALL, 8'h78,    1'b0, 8'h00},
      '{CFG_SHOW_ALL, CHAR_NL,  1'b0, 8'h00},
      // nonblank numbering overrides all-line numbering; ends marked
      '{CFG_NONBLANK, CHAR_NL, 1'b0, 8'h00},
      '{CFG_NONBLANK, CHAR_NL, 1'b0, 8'h00},
      '{CFG_NONBLANK, 8'h61,   1'b0, 8'h00},
      '{CFG_NONBLANK, CHAR_NL, 1'b0, 8'h00},
      '{CFG_NONBLANK, 8'h62,   1'b0, 8'h00},
      '{CFG_NONBLANK, 8'hFE,   1'b0, 8'h00}
   };

   text_stream_line_formatter_core #(
      .NUMBER_DIGITS (NDIG)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // Run guard: far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   // Right-justified line number plus tab, then bump the BCD counter.
   // The counter sticks at all nines.
   function automatic void put_line_number();
      bit         seen;
      bit         done;
      logic [3:0] d;
      seen = 1'b0;
      for (int i = NDIG - 1; i >= 0; i--) begin
         d = line_bcd[4*i +: 4];
         if (d != 4'd0 || i == 0)
            seen = 1'b1;
         run_bytes.push_back(seen ? CHAR_ZERO + {4'h0, d} : CHAR_SPACE);
      end
      run_bytes.push_back(CHAR_TAB);
      if (line_bcd != BCD_MAX) begin
         done = 1'b0;
         for (int i = 0; i < NDIG; i++) begin
            if (!done) begin
               if (line_bcd[4*i +: 4] < 4'd9) begin
                  line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
                  done = 1'b1;
               end else begin
                  line_bcd[4*i +: 4] = 4'd0;
               end
            end
         end
      end
   endfunction

   // Predicts the output of one accepted input byte; the beats are queued
   // unless the caller types its own expectation.
   function automatic void format_byte(input logic [7:0] in_b, input bit queue_it);
      logic [7:0] c;
      logic       nl;
      logic       kept;
      c  = in_b;
      nl = (c == CHAR_NL);
      run_bytes.delete();

      // blank-run count only moves while squeezing is on
      if (opts.squeeze_blank) begin
         if (nl) begin
            if (nl_run < 2'd3)
               nl_run = nl_run + 2'd1;
         end else begin
            nl_run = 2'd0;
         end
      end
      kept = !(opts.squeeze_blank && nl_run == 2'd3);

      if (opts.number_all_lines && !opts.number_nonblank_lines && kept) begin
         if (due_all) begin
            put_line_number();
            due_all = 1'b0;
         end
         if (nl)
            due_all = 1'b1;
      end

      if (opts.show_ends && nl && kept)
         run_bytes.push_back(CHAR_DOLLAR);

      if (opts.number_nonblank_lines) begin
         if (nl) begin
            due_nonblank = 1'b1;
         end else if (due_nonblank) begin
            put_line_number();
            due_nonblank = 1'b0;
         end
      end

      if (kept) begin
         if (opts.show_nonprinting &&
             (c <= 8'd8 || (c >= 8'd11 && c <= 8'd31) || c == CHAR_DEL)) begin
            c = (c + 8'd64) & 8'h7F;
            run_bytes.push_back(CHAR_CARET);
         end
         if (opts.show_tabs && c == CHAR_TAB) begin
            run_bytes.push_back(CHAR_CARET);
            run_bytes.push_back(CHAR_I);
         end else begin
            run_bytes.push_back(c);
         end
      end

      if (queue_it)
         foreach (run_bytes[k])
            pending_out.push_back('{data: run_bytes[k],
                                    end_of_run: (k == run_bytes.size() - 1)});
   endfunction

   // Offers one input byte, with an occasional gap first, and returns at the
   // edge where it is taken. req_tvalid stays high for a following byte.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (idle_on && $urandom_range(0, 99) < 4) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic feed(input logic [7:0] b);
      send_byte(b);
      format_byte(b, 1'b1);
   endtask

   // Stop sending and let the block run dry. A squeezed newline makes no
   // beat, so an empty expectation queue alone does not mean idle.
   task automatic drain_out();
      req_tvalid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_NUMBER_ALL:      opts.number_all_lines      = v;
         CSR_NUMBER_NONBLANK: opts.number_nonblank_lines = v;
         CSR_SQUEEZE_BLANK:   opts.squeeze_blank         = v;
         CSR_SHOW_ENDS:       opts.show_ends             = v;
         CSR_SHOW_TABS:       opts.show_tabs             = v;
         CSR_SHOW_NONPRINT:   opts.show_nonprinting      = v;
         default: ;
      endcase
   endtask

   // Options change only with the block idle; all six are rewritten each time.
   task automatic apply_cfg(input cfg_type c);
      drain_out();
      write_reg(CSR_NUMBER_ALL,      c.number_all_lines);
      write_reg(CSR_NUMBER_NONBLANK, c.number_nonblank_lines);
      write_reg(CSR_SQUEEZE_BLANK,   c.squeeze_blank);
      write_reg(CSR_SHOW_ENDS,       c.show_ends);
      write_reg(CSR_SHOW_TABS,       c.show_tabs);
      write_reg(CSR_SHOW_NONPRINT,   c.show_nonprinting);
      csr_valid <= 1'b0;
   endtask

   // Text-like random bytes: newline runs for squeeze and numbering, tabs,
   // control bytes, high bytes, printable text and some raw noise.
   task automatic send_random_text(input int n);
      int         sent;
      int         r;
      int         run;
      logic [7:0] b;
      sent = 0;
      while (sent < n) begin
         r = $urandom_range(0, 99);
         if (r < 22) begin
            run = $urandom_range(1, 4);
            repeat (run) begin
               feed(CHAR_NL);
               sent++;
            end
         end else begin
            if (r < 32)
               b = CHAR_TAB;
            else if (r < 42)
               b = ($urandom_range(0, 3) == 0) ? CHAR_DEL : 8'($urandom_range(0, 31));
            else if (r < 55)
               b = 8'($urandom_range(128, 255));
            else if (r < 60)
               b = 8'($urandom_range(0, 255));
            else
               b = 8'($urandom_range(32, 126));
            feed(b);
            sent++;
         end
      end
   endtask

   // Output side: checks each taken beat, then picks next cycle's tready.
   // The long hold is counted here so the input side keeps pushing meanwhile.
   always @(posedge clock) begin : rsp_side
      out_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_out.size() == 0) begin
            mism++;
            if (mism <= 10)
               $display("tb_top: unexpected beat data=%h last=%b", rsp_tdata, rsp_tlast);
         end else begin
            want = pending_out.pop_front();
            if (want.data !== rsp_tdata || want.end_of_run !== rsp_tlast) begin
               mism++;
               if (mism <= 10)
                  $display("tb_top: beat mismatch want data=%h last=%b got data=%h last=%b",
                           want.data, want.end_of_run, rsp_tdata, rsp_tlast);
            end
         end
      end
      if (hold_req && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idle_on && $urandom_range(0, 99) < 10);
      end
   end

   initial begin : stim
      cfg_type c;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (int i = 0; i < 24; i++) begin
         if (i == 0 || dir_rows[i].opts != opts)
            apply_cfg(dir_rows[i].opts);
         if (dir_rows[i].typed) begin
            send_byte(dir_rows[i].in_byte);
            format_byte(dir_rows[i].in_byte, 1'b0);   // keeps predictor state in step
            pending_out.push_back('{data: dir_rows[i].echo, end_of_run: 1'b1});
         end else begin
            feed(dir_rows[i].in_byte);
         end
      end

      // Random text under several option sets, extremes first.
      // Phase 2 takes the long output stall, phase 3 runs without any idling.
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 0)
            c = '1;
         else if (ph == 1)
            c = '0;
         else
            c = cfg_type'(6'($urandom_range(0, 63)));
         apply_cfg(c);
         idle_on = (ph != 3);
         if (ph == 2)
            hold_req = 1'b1;
         send_random_text(PHASE_BYTES);
      end

      // Line-number carry sweep: one numbered empty line per newline
      c = CFG_PLAIN;
      c.number_all_lines = 1'b1;
      c.show_ends        = 1'($urandom_range(0, 1));
      apply_cfg(c);
      idle_on = 1'b0;
      repeat (SWEEP_LINES) feed(CHAR_NL);
      idle_on = 1'b1;

      drain_out();
      if (mism == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/lnfmt_pkg.sv
rtl/core/lnfmt_front.sv
rtl/core/lnfmt_queue.sv
rtl/core/lnfmt_back.sv
rtl/core/text_stream_line_formatter_core.sv
tb/tb_top.sv
